// File: src/habf_pkg.sv
// ----------------------------------------------------------------------------
// habf_pkg: shared types and constants of the access unit boundary finder
// Payload structs of both channels, the classified byte token that runs
// between the front and the back, and configuration register layout.
// ----------------------------------------------------------------------------
package habf_pkg;

  // Default buffer limit; byte positions saturate one below it (20-bit cap).
  localparam longint unsigned MaxBufferBytesDflt = 64'd1048576;

  localparam int PosW = 20;

  // Token queue between front and back.
  localparam int FifoDepth = 4;

  // Configuration port.
  localparam int          CfgAddrW     = 3;
  localparam int          CfgDataW     = 32;
  localparam logic        RegPackStart = 1'b0;
  localparam logic [7:0]  PackStartRst = 8'd186;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic [1:0] vcl_start;
  } habf_in_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] boundary_offset;
    logic [1:0]      vcl_status;
  } habf_out_t;

  // One input byte with everything the scanner needs to know about it.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic [1:0] vcl_start;
    logic       is_zero;
    logic       is_one;
    logic       is_vcl;         // NAL type below 32
    logic       is_irap;        // NAL type 16..23
    logic       is_ps;          // VPS, SPS, PPS
    logic       is_l0_type;     // AUD, prefix SEI, 41..44, 48..55
    logic       layer_hi;       // layer id MSB as a first header byte
    logic       low_layer_zero; // layer id low bits zero as a second header byte
  } habf_tok_t;

endpackage

// File: src/habf_front.sv
// ----------------------------------------------------------------------------
// habf_front: byte classifier and token queue
// Decode each accepted byte into a token and hold it in a short queue until
// the scanner takes it.
// ----------------------------------------------------------------------------
module habf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  habf_pkg::habf_in_t in_data,
  output logic               tok_valid,
  output habf_pkg::habf_tok_t tok,
  input  logic               tok_take
);
  import habf_pkg::*;

  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = $clog2(FifoDepth + 1);

  habf_tok_t           tok_in;
  logic [5:0]          hdr_type;
  habf_tok_t           mem_r [FifoDepth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                wr_en, rd_en;

  assign hdr_type = in_data.data_byte[6:1];

  always_comb begin
    tok_in.data_byte      = in_data.data_byte;
    tok_in.first_byte     = in_data.first_byte;
    tok_in.last_byte      = in_data.last_byte;
    tok_in.vcl_start      = in_data.vcl_start;
    tok_in.is_zero        = (in_data.data_byte == 8'd0);
    tok_in.is_one         = (in_data.data_byte == 8'd1);
    tok_in.is_vcl         = (hdr_type < 6'd32);
    tok_in.is_irap        = (hdr_type inside {[6'd16:6'd23]});
    tok_in.is_ps          = (hdr_type inside {[6'd32:6'd34]});
    tok_in.is_l0_type     = (hdr_type inside {6'd35, 6'd39, [6'd41:6'd44], [6'd48:6'd55]});
    tok_in.layer_hi       = in_data.data_byte[0];
    tok_in.low_layer_zero = (in_data.data_byte[7:3] == 5'd0);
  end

  assign full      = (count_r == CntW'(FifoDepth));
  assign tok_valid = (count_r != '0);
  assign tok       = mem_r[rd_ptr_r];
  assign wr_en     = push && !full;
  assign rd_en     = tok_take && tok_valid;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= tok_in;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(FifoDepth))
    else $error("token queue count beyond depth");

  a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> !rd_en)
    else $error("token taken from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> (count_r == $past(count_r) + 1'b1))
    else $error("token queue count lost a write");
`endif

endmodule

// File: src/habf_back.sv
// ----------------------------------------------------------------------------
// habf_back: start code scanner and result register
// Take one token a cycle while the result register is free or being popped,
// track start codes, NAL headers and VCL status, and load a result beat into
// the output register.
module habf_back #(
  parameter longint unsigned MAX_BUFFER_BYTES = habf_pkg::MaxBufferBytesDflt
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          pack_start_byte,
  input  logic                tok_valid,
  input  habf_pkg::habf_tok_t tok,
  output logic                tok_take,
  output logic                empty,
  input  logic                pop,
  output habf_pkg::habf_out_t out_data
);
  import habf_pkg::*;

  localparam longint unsigned CapL =
    ((MAX_BUFFER_BYTES - 64'd1) < 64'hFFFFF) ? (MAX_BUFFER_BYTES - 64'd1) : 64'hFFFFF;
  localparam logic [PosW-1:0] PosCap = CapL[PosW-1:0];

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhHdr0 = 2'd1;
  localparam logic [1:0] PhHdr1 = 2'd2;
  localparam logic [1:0] PhPay  = 2'd3;

  localparam logic [1:0] VclNone    = 2'd0;
  localparam logic [1:0] VclNonIrap = 2'd1;
  localparam logic [1:0] VclIrap    = 2'd2;
  localparam logic [1:0] VclCorrupt = 2'd3;

  typedef struct packed {
    logic       is_vcl;
    logic       is_irap;
    logic       is_ps;
    logic       is_l0_type;
    logic [7:0] h0;
    logic       layer_zero;
  } hdr_t;

  logic [1:0]      zr_r, zr_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [1:0]      ph_r, ph_nxt;
  hdr_t            hdr_r, hdr_nxt;
  logic [PosW-1:0] pend_r, pend_nxt;
  logic [1:0]      trk_r, trk_nxt;
  logic            done_r, done_nxt;
  logic            out_valid_r, out_valid_nxt;
  habf_out_t       out_r, out_nxt;

  logic            advance;
  logic            close_req, full_nal, opens, hit;
  logic [PosW-1:0] cur, lead;

  assign advance  = !out_valid_r || pop;
  assign tok_take = tok_valid && advance;
  assign empty    = !out_valid_r;
  assign out_data = out_r;

  always_comb begin
    zr_nxt        = zr_r;
    pos_nxt       = pos_r;
    ph_nxt        = ph_r;
    hdr_nxt       = hdr_r;
    pend_nxt      = pend_r;
    trk_nxt       = trk_r;
    done_nxt      = done_r;
    out_valid_nxt = advance ? 1'b0 : out_valid_r;
    out_nxt       = out_r;
    close_req     = 1'b0;
    full_nal      = 1'b0;
    opens         = 1'b0;
    hit           = 1'b0;
    cur           = pos_r;
    lead          = '0;

    if (tok_take) begin
      // A new buffer restarts the scan and loads the caller's status.
      if (tok.first_byte) begin
        pos_nxt  = '0;
        zr_nxt   = '0;
        ph_nxt   = PhIdle;
        done_nxt = 1'b0;
        trk_nxt  = tok.vcl_start;
      end
      if (!done_nxt) begin
        cur     = pos_nxt;
        pos_nxt = (cur < PosCap) ? cur + 1'b1 : PosCap;

        case (ph_nxt)
          PhHdr0: begin
            hdr_nxt.is_vcl     = tok.is_vcl;
            hdr_nxt.is_irap    = tok.is_irap;
            hdr_nxt.is_ps      = tok.is_ps;
            hdr_nxt.is_l0_type = tok.is_l0_type;
            hdr_nxt.h0         = tok.data_byte;
            hdr_nxt.layer_zero = !tok.layer_hi;
            if (tok.last_byte) begin
              close_req = 1'b1;
              ph_nxt    = PhIdle;
            end else begin
              ph_nxt = PhHdr1;
            end
          end
          PhHdr1: begin
            hdr_nxt.layer_zero = hdr_r.layer_zero && tok.low_layer_zero;
            if (tok.last_byte) begin
              close_req = 1'b1;
              ph_nxt    = PhIdle;
            end else begin
              ph_nxt = PhPay;
            end
          end
          PhPay: begin
            close_req = 1'b1;
            full_nal  = 1'b1;
            ph_nxt    = PhIdle;
          end
          default: begin
          end
        endcase

        // Close the NAL: new access unit, status update, or corrupt mark.
        if (close_req) begin
          opens = hdr_nxt.is_ps || (hdr_nxt.layer_zero && hdr_nxt.is_l0_type) ||
                  (hdr_nxt.is_vcl && tok.data_byte[7]);
          if ((trk_nxt != VclNone) && full_nal && opens) begin
            hit = 1'b1;
          end else if (hdr_nxt.is_vcl) begin
            trk_nxt = hdr_nxt.is_irap ? VclIrap : VclNonIrap;
          end else if (hdr_nxt.h0 == pack_start_byte) begin
            trk_nxt = VclCorrupt;
            hit     = 1'b1;
          end
        end

        if (hit) begin
          done_nxt                = 1'b1;
          out_valid_nxt           = 1'b1;
          out_nxt.found           = 1'b1;
          out_nxt.boundary_offset = pend_r;
          out_nxt.vcl_status      = trk_nxt;
        end else begin
          if ((ph_nxt == PhIdle) && tok.is_one && (zr_nxt >= 2'd2) && !tok.last_byte) begin
            lead     = (zr_nxt == 2'd3) ? PosW'(3) : PosW'(2);
            pend_nxt = (cur >= lead) ? cur - lead : '0;
            ph_nxt   = PhHdr0;
          end
          zr_nxt = tok.is_zero ? ((zr_nxt == 2'd3) ? 2'd3 : zr_nxt + 1'b1) : 2'd0;
          if (tok.last_byte) begin
            done_nxt                = 1'b1;
            ph_nxt                  = PhIdle;
            out_valid_nxt           = 1'b1;
            out_nxt.found           = 1'b0;
            out_nxt.boundary_offset = '0;
            out_nxt.vcl_status      = trk_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zr_r        <= '0;
      pos_r       <= '0;
      ph_r        <= PhIdle;
      pend_r      <= '0;
      trk_r       <= VclNone;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      zr_r        <= zr_nxt;
      pos_r       <= pos_nxt;
      ph_r        <= ph_nxt;
      pend_r      <= pend_nxt;
      trk_r       <= trk_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_found_has_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.found) |-> (out_r.vcl_status != VclNone))
    else $error("boundary reported without VCL status");

  a_miss_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.found) |-> (out_r.boundary_offset == '0))
    else $error("no-boundary beat with nonzero offset");

  a_pos_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r <= PosCap) && (pend_r <= PosCap))
    else $error("byte position beyond cap");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && tok_take && !tok.first_byte) |=> (pos_r == $past(pos_r)))
    else $error("scanner advanced after buffer finished");
`endif

endmodule

// File: src/hevc_access_unit_boundary_finder_core.sv
// ----------------------------------------------------------------------------
// hevc_access_unit_boundary_finder_core: H.265 access unit boundary finder
// Scan an Annex B buffer a byte per beat and report the start code offset of
// the first NAL that opens a new access unit, or a no-boundary beat at the end.
//
//   channel  handshake           payload         direction
//   input    push / full         in_data         in  (one byte per beat)
//   result   empty / pop         out_data        out (at most one per buffer)
//   config   psel/penable/pready paddr/pwdata    APB write, prdata read back
//
// Throughput is one byte per cycle unless a held result waits to be popped.
// A byte that causes a result is first written into a queue entry when it is
// accepted; the scanner takes that entry once the result register is free and
// registers the result in the result register.
// Reset is synchronous on rst_n low; queue, scanner state and result are
// cleared and pack_start_byte returns to 186.
// A held result stalls the scanner only; the queue keeps taking bytes until
// its four entries are full.
// ----------------------------------------------------------------------------
module hevc_access_unit_boundary_finder_core #(
  parameter longint unsigned MAX_BUFFER_BYTES = habf_pkg::MaxBufferBytesDflt
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          push,
  output logic                          full,
  input  habf_pkg::habf_in_t            in_data,
  // result channel
  output logic                          empty,
  input  logic                          pop,
  output habf_pkg::habf_out_t           out_data,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [habf_pkg::CfgAddrW-1:0] paddr,
  input  logic [habf_pkg::CfgDataW-1:0] pwdata,
  output logic [habf_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import habf_pkg::*;

  logic [7:0]  psb_r, psb_nxt;
  logic        cfg_wr;
  logic        tok_valid, tok_take;
  habf_tok_t   tok;

  // Registers sit on 4-byte words; bit 2 picks the word.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    psb_nxt = psb_r;
    if (cfg_wr && (paddr[2] == RegPackStart)) begin
      psb_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psb_r <= PackStartRst;
    end else begin
      psb_r <= psb_nxt;
    end
  end

  assign prdata = (paddr[2] == RegPackStart) ? {{(CfgDataW-8){1'b0}}, psb_r} : '0;

  // Front: classify bytes and queue them.
  habf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_take  (tok_take)
  );

  // Back: scan tokens and hold the result beat; the lost data check uses the
  // current pack start byte when the NAL closes.
  habf_back #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pack_start_byte (psb_r),
    .tok_valid       (tok_valid),
    .tok             (tok),
    .tok_take        (tok_take),
    .empty           (empty),
    .pop             (pop),
    .out_data        (out_data)
  );

endmodule
